/* src/rcs_pkg.sv */
// Shared types and constants for the RMS channel selector.
// Depends on nothing; every other source file imports it.
`default_nettype none

package rcs_pkg;

   localparam int CH_BITS         = 6;
   localparam int OUT_CH_BITS     = 7;
   localparam int SAMPLE_W        = 16;
   localparam int SAMPLE_MAX_BITS = 24;
   localparam int MS_BITS         = 40;
   localparam int W_BITS          = 16;
   localparam int THR_BITS        = 16;
   localparam int MASK_BITS       = 64;
   localparam int CSR_IDX_BITS    = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_BITS-1:0] CSR_RMS_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_EMA_WEIGHT    = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CHANNEL_MASK  = 2'd2;

   // Reset values; the threshold is kept squared in Q32.8 (100 * 100 * 256).
   localparam logic [MS_BITS-1:0]   RST_THR_SQ = 40'd2560000;
   localparam logic [W_BITS-1:0]    RST_WEIGHT = 16'd65000;
   localparam logic [MASK_BITS-1:0] RST_MASK   = {MASK_BITS{1'b1}};

   // Unity weight, 1.0 in the 16-bit fraction of the decay weight.
   localparam logic [W_BITS:0] WEIGHT_ONE = 17'd65536;

   typedef struct packed {
      logic [CH_BITS-1:0]         channel;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last_in_packet;
   } rcs_req_type;

   typedef struct packed {
      logic [OUT_CH_BITS-1:0] selected_channel;
      logic [MS_BITS-1:0]     selected_mean_square;
   } rcs_rsp_type;

   typedef struct packed {
      logic               re;
      logic [CH_BITS-1:0] raddr;
      logic               we;
      logic [CH_BITS-1:0] waddr;
      logic [MS_BITS-1:0] wdata;
      logic               clear;
   } rcs_mem_req_type;

endpackage

`default_nettype wire

/* src/rcs_ema_mem.sv */
// Mean-square store: one synchronous RAM with a registered read port and
// per-entry valid bits. Depends on rcs_pkg.
`default_nettype none

module rcs_ema_mem #(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  rcs_pkg::rcs_mem_req_type mem_req,
   input  logic [rcs_pkg::MS_BITS-1:0] thr_sq,
   output logic [rcs_pkg::MS_BITS-1:0] rdata
);
   import rcs_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [MS_BITS-1:0] ram_ff [DEPTH];
   logic [MS_BITS-1:0] rd_data_ff;
   logic               rd_vld_ff;
   logic               rd_vld_in;
   logic [DEPTH-1:0]   vld_ff;
   logic [DEPTH-1:0]   vld_in;

   // An entry that was never written since the last reload holds the
   // threshold squared.
   assign rdata = rd_vld_ff ? rd_data_ff : thr_sq;

   always_comb begin
      vld_in = vld_ff;
      if (mem_req.clear) begin
         vld_in = '0;
      end else if (mem_req.we) begin
         vld_in[mem_req.waddr[AW-1:0]] = 1'b1;
      end
      rd_vld_in = rd_vld_ff;
      if (mem_req.re) begin
         rd_vld_in = vld_ff[mem_req.raddr[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         vld_ff    <= vld_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         ram_ff[mem_req.waddr[AW-1:0]] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rd_data_ff <= ram_ff[mem_req.raddr[AW-1:0]];
      end
   end

endmodule

`default_nettype wire

/* src/rcs_ema_calc.sv */
// Exponential mean-square update: two registered products, then their sum
// scaled down by 2^16. Depends on rcs_pkg.
`default_nettype none

module rcs_ema_calc (
   input  logic                        clock,
   input  logic                        start,
   input  logic [rcs_pkg::MS_BITS-1:0] ema_value,
   input  logic [rcs_pkg::MS_BITS-1:0] sq_value,
   input  logic [rcs_pkg::W_BITS-1:0]  weight,
   output logic [rcs_pkg::MS_BITS-1:0] nv
);
   import rcs_pkg::*;

   localparam int OLD_BITS = W_BITS + MS_BITS;
   localparam int NEW_BITS = W_BITS + 1 + MS_BITS;
   localparam int SUM_BITS = NEW_BITS + 1;

   logic [OLD_BITS-1:0] p_old_ff;
   logic [NEW_BITS-1:0] p_new_ff;
   logic [W_BITS:0]     w_rest;
   logic [SUM_BITS-1:0] sum_w;

   assign w_rest = WEIGHT_ONE - {1'b0, weight};

   always_ff @(posedge clock) begin
      if (start) begin
         p_old_ff <= OLD_BITS'(weight) * OLD_BITS'(ema_value);
         p_new_ff <= NEW_BITS'(w_rest) * NEW_BITS'(sq_value);
      end
   end

   // The weighted sum stays below 2^56, so the result fits 40 bits.
   assign sum_w = SUM_BITS'(p_old_ff) + SUM_BITS'(p_new_ff);
   assign nv    = sum_w[16 +: MS_BITS];

endmodule

`default_nettype wire

/* src/rms_channel_selector_unit.sv */
// Top level of the RMS channel selector: sequencer, configuration registers,
// best-channel tracking. Depends on rcs_pkg, rcs_ema_mem and rcs_ema_calc.
`default_nettype none

// Channel   Handshake              Word                  Direction
// req       req_valid / req_stall  rcs_req_type          in
// rsp       rsp_valid / rsp_stall  rcs_rsp_type          out
// csr       csr_valid / csr_ready  csr_index, csr_data   in
//
// A word on a selected channel passes through accept and RAM read, the
// registered products, then the sum and write-back, as a read-modify-write
// of the store. A word on an unselected channel leaves the block idle.
// A word that ends a packet then adds these steps: read of the current
// channel, decision, read of the chosen channel and loading of the output
// register, which waits while the output register is still full.
// Reset is synchronous; it clears the control state and all store valid
// bits at once, so no clearing pass is needed. The output register lets a
// new word in while a result waits for a stalled receiver.

module rms_channel_selector_unit #(
   parameter int CHANNELS    = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  rcs_pkg::rcs_req_type             req_word,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output rcs_pkg::rcs_rsp_type             rsp_word,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rcs_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [rcs_pkg::MASK_BITS-1:0]    csr_data
);
   import rcs_pkg::*;

   // Channels at or above CHANNELS never take part in selection.
   localparam logic [MASK_BITS-1:0] CHAN_LIM = (CHANNELS >= MASK_BITS) ?
      {MASK_BITS{1'b1}} : ((64'd1 << CHANNELS) - 64'd1);
   localparam int SQ_BITS = 2 * SAMPLE_BITS;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_READ   = 3'd1;
   localparam logic [2:0] ST_UPDATE = 3'd2;
   localparam logic [2:0] ST_CUR_RD = 3'd3;
   localparam logic [2:0] ST_DECIDE = 3'd4;
   localparam logic [2:0] ST_OUT_RD = 3'd5;
   localparam logic [2:0] ST_OUT    = 3'd6;

   // Lowest set bit of a mask; channel 0 when the mask is empty.
   function automatic logic [CH_BITS-1:0] first_set(input logic [MASK_BITS-1:0] m);
      logic [CH_BITS-1:0] idx;
      logic               found;
      idx   = '0;
      found = 1'b0;
      for (int c = 0; c < MASK_BITS; c++) begin
         if (m[c] && !found) begin
            idx   = CH_BITS'(c);
            found = 1'b1;
         end
      end
      return idx;
   endfunction

   logic [2:0]           state_ff,    state_in;
   logic [MS_BITS-1:0]   thr_sq_ff,   thr_sq_in;
   logic [W_BITS-1:0]    weight_ff,   weight_in;
   logic [MASK_BITS-1:0] mask_ff,     mask_in;
   logic [CH_BITS-1:0]   cur_ff,      cur_in;
   logic [MS_BITS-1:0]   best_val_ff, best_val_in;
   logic [CH_BITS-1:0]   best_ch_ff,  best_ch_in;
   logic                 best_vld_ff, best_vld_in;
   logic [CH_BITS-1:0]   item_ch_ff;
   logic                 item_last_ff;
   logic [MS_BITS-1:0]   item_sq_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rcs_rsp_type          rsp_word_ff,  rsp_word_in;

   logic                       req_fire;
   logic                       csr_fire;
   logic [MASK_BITS-1:0]       usable_mask;
   logic                       usable;
   logic [SAMPLE_MAX_BITS-1:0] sample_ext;
   logic [SAMPLE_BITS-1:0]     raw;
   logic [SAMPLE_BITS-1:0]     mag;
   logic [SQ_BITS-1:0]         mag_sq;
   logic [63:0]                sq_wide;
   logic [MS_BITS-1:0]         sq_sat;
   logic [THR_BITS-1:0]        thr_new;
   logic [2*THR_BITS-1:0]      thr_new_sq;
   logic                       rsp_free;

   rcs_mem_req_type    mem_req;
   logic [MS_BITS-1:0] mem_rdata;
   logic [MS_BITS-1:0] nv;

   // Input side is held off while an item is in flight or under reset.
   assign req_stall = reset || (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = !reset;
   assign csr_fire  = csr_valid && csr_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign usable_mask = mask_ff & CHAN_LIM;
   assign usable      = usable_mask[req_word.channel];

   // The sample is taken as a SAMPLE_BITS two's complement value; squaring
   // the magnitude gives s*s, which is moved to Q32.8 and saturated.
   assign sample_ext = {{(SAMPLE_MAX_BITS - SAMPLE_W){1'b0}}, req_word.sample};
   assign raw        = sample_ext[SAMPLE_BITS-1:0];
   assign mag        = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
   assign mag_sq     = SQ_BITS'(mag) * SQ_BITS'(mag);
   assign sq_wide    = 64'(mag_sq) << 8;
   assign sq_sat     = (|sq_wide[63:MS_BITS]) ? {MS_BITS{1'b1}} : sq_wide[MS_BITS-1:0];

   // The threshold is held squared in Q32.8, the form every compare uses.
   assign thr_new    = csr_data[THR_BITS-1:0];
   assign thr_new_sq = (2*THR_BITS)'(thr_new) * (2*THR_BITS)'(thr_new);

   // RAM requests. Accesses never overlap: the write-back of one item lands
   // before any later read is issued, so no forwarding is required.
   always_comb begin
      mem_req.re    = 1'b0;
      mem_req.raddr = cur_ff;
      case (state_ff)
         ST_IDLE: begin
            mem_req.re    = req_fire && usable;
            mem_req.raddr = req_word.channel;
         end
         ST_CUR_RD, ST_OUT_RD: begin
            mem_req.re = 1'b1;
         end
         default: begin
            mem_req.re = 1'b0;
         end
      endcase
      mem_req.we    = (state_ff == ST_UPDATE);
      mem_req.waddr = item_ch_ff;
      mem_req.wdata = nv;
      mem_req.clear = csr_fire && (csr_index == CSR_RMS_THRESHOLD);
   end

   rcs_ema_mem #(
      .DEPTH (CHANNELS)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .thr_sq  (thr_sq_ff),
      .rdata   (mem_rdata)
   );

   rcs_ema_calc u_calc (
      .clock     (clock),
      .start     (state_ff == ST_READ),
      .ema_value (mem_rdata),
      .sq_value  (item_sq_ff),
      .weight    (weight_ff),
      .nv        (nv)
   );

   always_comb begin
      state_in     = state_ff;
      thr_sq_in    = thr_sq_ff;
      weight_in    = weight_ff;
      mask_in      = mask_ff;
      cur_in       = cur_ff;
      best_val_in  = best_val_ff;
      best_ch_in   = best_ch_ff;
      best_vld_in  = best_vld_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;

      // Configuration writes must come only while the block is idle, which it
      // does not enforce. A threshold write reloads all entries via valid bits.
      if (csr_fire) begin
         case (csr_index)
            CSR_RMS_THRESHOLD: begin
               thr_sq_in   = {thr_new_sq, 8'd0};
               best_vld_in = 1'b0;
            end
            CSR_EMA_WEIGHT: begin
               weight_in = csr_data[W_BITS-1:0];
            end
            CSR_CHANNEL_MASK: begin
               mask_in     = csr_data;
               cur_in      = first_set(csr_data & CHAN_LIM);
               best_vld_in = 1'b0;
            end
            default: begin
               thr_sq_in = thr_sq_ff;
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (usable) begin
                  state_in = ST_READ;
               end else if (req_word.last_in_packet) begin
                  state_in = ST_CUR_RD;
               end
            end
         end
         ST_READ: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            // Strictly greater wins, so on a tie the earlier item stays.
            if (!best_vld_ff || (nv > best_val_ff)) begin
               best_val_in = nv;
               best_ch_in  = item_ch_ff;
               best_vld_in = 1'b1;
            end
            state_in = item_last_ff ? ST_CUR_RD : ST_IDLE;
         end
         ST_CUR_RD: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            // Switch away only when the current channel has gone quiet.
            if ((mem_rdata <= thr_sq_ff) && best_vld_ff) begin
               cur_in = best_ch_ff;
            end
            best_vld_in = 1'b0;
            best_val_in = '0;
            best_ch_in  = '0;
            state_in    = ST_OUT_RD;
         end
         ST_OUT_RD: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // Read data stays put while the output register is still full.
            if (rsp_free) begin
               rsp_valid_in                     = 1'b1;
               rsp_word_in.selected_channel     = OUT_CH_BITS'(cur_ff) + 1'b1;
               rsp_word_in.selected_mean_square = mem_rdata;
               state_in                         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_sq_ff    <= RST_THR_SQ;
         weight_ff    <= RST_WEIGHT;
         mask_ff      <= RST_MASK;
         cur_ff       <= first_set(RST_MASK & CHAN_LIM);
         best_val_ff  <= '0;
         best_ch_ff   <= '0;
         best_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_sq_ff    <= thr_sq_in;
         weight_ff    <= weight_in;
         mask_ff      <= mask_in;
         cur_ff       <= cur_in;
         best_val_ff  <= best_val_in;
         best_ch_ff   <= best_ch_in;
         best_vld_ff  <= best_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ch_ff   <= req_word.channel;
         item_last_ff <= req_word.last_in_packet;
         item_sq_ff   <= sq_sat;
      end
      rsp_word_ff <= rsp_word_in;
   end

endmodule

`default_nettype wire

/* src/rcs_checker.sv */
// Port-level checks for the RMS channel selector, bound to the top level.
// Depends on rcs_pkg and rms_channel_selector_unit.
`default_nettype none

module rcs_checker #(
   parameter int CHANNELS = 64
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input rcs_pkg::rcs_rsp_type rsp_word
);
   import rcs_pkg::*;

   // A held result keeps its word until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   // The selected channel is one-based and inside the configured range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.selected_channel != 0) &&
                    (rsp_word.selected_channel <= OUT_CH_BITS'(CHANNELS)))
      else $error("selected channel out of range");

   // A stalled input word stays offered until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid)
      else $error("input word withdrawn while stalled");

   // Reset empties the output register.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

endmodule

bind rms_channel_selector_unit rcs_checker #(
   .CHANNELS (CHANNELS)
) u_rcs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

`default_nettype wire

/* verif/rms_channel_selector_unit_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for rms_channel_selector_unit: a scoreboard class predicts each
// packet's channel decision, and plain tasks drive packets and register writes.
// Depends on rcs_pkg and the rms_channel_selector_unit RTL.

module rms_channel_selector_unit_test;
   import rcs_pkg::*;

   // Index 3 lies beyond the register list, so a write there must change nothing.
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED = 2'd3;

   // A word that ends no packet keeps the block busy only until its write-back.
   // The settle wait is plenty before a register write.
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_WORDS   = 90;
   localparam int PHASES        = 8;

   // The scoreboard keeps its own copy of the registers, the mean-square store
   // and the best-channel tracking. It queues one expected selection for each
   // word that ends a packet.
   class selection_scoreboard;
      logic [THR_BITS-1:0]  thr_reg;
      logic [W_BITS-1:0]    weight_reg;
      logic [MASK_BITS-1:0] mask_reg;
      logic [MS_BITS-1:0]   ms_store [64];
      logic [CH_BITS-1:0]   cur_ch;
      logic [MS_BITS-1:0]   best_ms;
      logic [CH_BITS-1:0]   best_ch;
      logic                 best_ok;
      rcs_rsp_type          awaited_picks [$];
      int                   mismatches;

      function new();
         thr_reg    = 16'd100;
         weight_reg = RST_WEIGHT;
         mask_reg   = RST_MASK;
         best_ms    = '0;
         best_ch    = '0;
         best_ok    = 1'b0;
         mismatches = 0;
         reload_store();
         pick_first();
      endfunction

      // The threshold squared, in the Q32.8 format of the store.
      function logic [MS_BITS-1:0] thr_squared();
         logic [63:0] t;
         t = {48'd0, thr_reg};
         return MS_BITS'((t * t) << 8);
      endfunction

      function void reload_store();
         foreach (ms_store[i]) ms_store[i] = thr_squared();
      endfunction

      // Lowest selected channel. An empty mask falls back to channel 0.
      function void pick_first();
         cur_ch = '0;
         for (int c = 63; c >= 0; c--) begin
            if (mask_reg[c]) cur_ch = CH_BITS'(c);
         end
      endfunction

      function void write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [MASK_BITS-1:0] data);
         case (idx)
            CSR_RMS_THRESHOLD: begin
               thr_reg = data[THR_BITS-1:0];
               reload_store();
               best_ok = 1'b0;
            end
            CSR_EMA_WEIGHT: begin
               weight_reg = data[W_BITS-1:0];
            end
            CSR_CHANNEL_MASK: begin
               mask_reg = data;
               pick_first();
               best_ok = 1'b0;
            end
            default: begin
            end
         endcase
      endfunction

      function void take_sample(rcs_req_type w);
         logic [16:0]        mag;
         logic [63:0]        sq;
         logic [63:0]        wt;
         logic [63:0]        nv;
         rcs_rsp_type        pick;
         if (mask_reg[w.channel]) begin
            mag = w.sample[SAMPLE_W-1] ? (17'h1_0000 - {1'b0, w.sample}) : {1'b0, w.sample};
            sq  = ({47'd0, mag} * {47'd0, mag}) << 8;
            if (sq > {24'd0, {MS_BITS{1'b1}}}) sq = {24'd0, {MS_BITS{1'b1}}};
            wt = {48'd0, weight_reg};
            nv = (wt * {24'd0, ms_store[w.channel]} + ({47'd0, WEIGHT_ONE} - wt) * sq) >> 16;
            ms_store[w.channel] = nv[MS_BITS-1:0];
            // Strictly greater only, so on a tie the earlier word stays best.
            if (!best_ok || nv[MS_BITS-1:0] > best_ms) begin
               best_ms = nv[MS_BITS-1:0];
               best_ch = w.channel;
               best_ok = 1'b1;
            end
         end
         if (w.last_in_packet) begin
            if (ms_store[cur_ch] <= thr_squared() && best_ok) cur_ch = best_ch;
            best_ok = 1'b0;
            best_ms = '0;
            best_ch = '0;
            pick.selected_channel     = {1'b0, cur_ch} + 7'd1;
            pick.selected_mean_square = ms_store[cur_ch];
            awaited_picks.insert(awaited_picks.size(), pick);
         end
      endfunction

      function void check_selection(rcs_rsp_type got);
         rcs_rsp_type want;
         if (awaited_picks.size() == 0) begin
            $display("%0t: result with none awaited: channel %0d, mean square %0d",
                     $time, got.selected_channel, got.selected_mean_square);
            mismatches++;
            return;
         end
         want = awaited_picks.pop_front();
         if (got.selected_channel !== want.selected_channel) begin
            $display("%0t: selected_channel expected %0d, actual %0d",
                     $time, want.selected_channel, got.selected_channel);
            mismatches++;
         end
         if (got.selected_mean_square !== want.selected_mean_square) begin
            $display("%0t: selected_mean_square expected %0d, actual %0d",
                     $time, want.selected_mean_square, got.selected_mean_square);
            mismatches++;
         end
      endfunction
   endclass

   logic                    clock     = 1'b0;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   rcs_req_type             req_word  = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   rcs_rsp_type             rsp_word;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [MASK_BITS-1:0]    csr_data  = '0;

   // Chance in percent, per cycle, that the sender idles or the receiver stalls.
   int idle_pct    = 0;
   int stall_pct   = 0;
   int cycle_count = 0;

   // Phase idling patterns: none, sender idles, receiver stalls, both lightly.
   int send_gaps [4]   = '{0, 82, 0, 6};
   int recv_stalls [4] = '{0, 0, 82, 6};

   selection_scoreboard board = new();

   rms_channel_selector_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // The receiver checks the values that were present before the edge. It then
   // draws its stall for the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_selection(rsp_word);
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // A hung handshake must not keep the run alive.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Offers one word after a random idle gap and holds it until it is taken.
   // The scoreboard learns of the word only when the block accepts it.
   task automatic send_word(input logic [CH_BITS-1:0] ch, input logic signed [SAMPLE_W-1:0] s,
                            input logic last);
      rcs_req_type w;
      w.channel        = ch;
      w.sample         = s;
      w.last_in_packet = last;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      board.take_sample(w);
   endtask

   // Stops sending and waits until every selection has arrived. The block may
   // still be working on a word that yields no result, so a settling wait follows.
   task automatic settle();
      req_valid <= 1'b0;
      while (board.awaited_picks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [MASK_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Half the samples sit near the threshold so that decisions go both ways. The
   // rest are full-range, tiny, zero or an extreme value.
   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      int   mag;
      logic neg;
      neg = $urandom_range(1);
      case ($urandom_range(5))
         0, 1, 2: mag = $urandom_range(2 * board.thr_reg + 20);
         3: return SAMPLE_W'($urandom);
         4: mag = $urandom_range(50);
         default: mag = $urandom_range(1) ? 32768 : 0;
      endcase
      if (mag > 32768) mag = 32768;
      if (mag > 32767 && !neg) mag = 32767;
      return neg ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
   endfunction

   // The upper data bits of the 16-bit registers are random. The block must
   // ignore them. The threshold write is sometimes skipped, so that mean
   // squares carry over from one phase to the next.
   task automatic load_random_config();
      logic [W_BITS-1:0]    wgt;
      logic [THR_BITS-1:0]  thr_val;
      logic [MASK_BITS-1:0] m;
      case ($urandom_range(3))
         0: wgt = '0;
         1: wgt = '1;
         2: wgt = RST_WEIGHT;
         default: wgt = W_BITS'($urandom);
      endcase
      case ($urandom_range(4))
         0: thr_val = '0;
         1: thr_val = '1;
         2: thr_val = THR_BITS'($urandom);
         default: thr_val = THR_BITS'($urandom_range(400));
      endcase
      case ($urandom_range(4))
         0: m = '1;
         1: m = 64'd1 << $urandom_range(63);
         2: m = {$urandom, $urandom} & {$urandom, $urandom};
         default: m = {$urandom, $urandom};
      endcase
      if (m == '0) m = '1;
      write_csr(CSR_EMA_WEIGHT, {16'($urandom), 32'($urandom), wgt});
      if ($urandom_range(2) != 0) begin
         write_csr(CSR_RMS_THRESHOLD, {16'($urandom), 32'($urandom), thr_val});
      end
      write_csr(CSR_CHANNEL_MASK, m);
   endtask

   // Most packets are well formed: channels ascend and the last word is
   // flagged. A few cover all 64 channels. The rest are noise: random
   // channels and random end flags, so some packets run on without an end.
   task automatic run_phase(input int words, input int send_gap, input int recv_stall);
      int sent;
      int kind;
      int ch;
      int size;
      int chans [$];
      idle_pct  = send_gap;
      stall_pct = recv_stall;
      sent      = 0;
      while (sent < words) begin
         chans.delete();
         kind = $urandom_range(99);
         if (kind < 8) begin
            for (int c = 0; c < 64; c++) chans.insert(chans.size(), c);
         end else if (kind < 85) begin
            ch   = $urandom_range(24);
            size = $urandom_range(1, 10);
            while (ch < 64 && chans.size() < size) begin
               chans.insert(chans.size(), ch);
               ch += $urandom_range(1, 8);
            end
         end else begin
            size = $urandom_range(1, 6);
            repeat (size) chans.insert(chans.size(), $urandom_range(63));
         end
         for (int i = 0; i < chans.size(); i++) begin
            send_word(CH_BITS'(chans[i]), pick_sample(),
                      (kind < 85) ? (i == chans.size() - 1) : ($urandom_range(2) == 0));
         end
         sent += chans.size();
         // Now and then the sender holds off until the pipeline is empty.
         if ($urandom_range(39) == 0) settle();
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset settings. Sample extremes, then the lowest and highest channels.
      send_word(6'd0, 16'sh7FFF, 1'b0);
      send_word(6'd1, 16'sh8000, 1'b0);
      send_word(6'd2, 16'sh0000, 1'b0);
      send_word(6'd63, 16'shFFFF, 1'b1);
      // A packet of a single word.
      send_word(6'd5, 16'sd200, 1'b1);
      // Out-of-order and repeated channels.
      send_word(6'd10, 16'sd50, 1'b0);
      send_word(6'd3, -16'sd50, 1'b0);
      send_word(6'd10, -16'sd50, 1'b1);
      // Two untouched channels with equal updates: the earlier one must win.
      send_word(6'd7, 16'sd300, 1'b0);
      send_word(6'd8, -16'sd300, 1'b1);

      // Only channels 4 and 63 are selected. Unselected words still end packets.
      settle();
      write_csr(CSR_CHANNEL_MASK, 64'h8000_0000_0000_0010);
      send_word(6'd0, 16'sd1000, 1'b0);
      send_word(6'd4, 16'sd90, 1'b0);
      send_word(6'd63, 16'sd5000, 1'b1);
      // A packet without any selected word keeps the current channel.
      send_word(6'd1, 16'sd7, 1'b1);

      // An empty mask falls back to channel 0.
      settle();
      write_csr(CSR_CHANNEL_MASK, '0);
      send_word(6'd2, 16'sd123, 1'b1);

      // A write beyond the register list, then zero threshold and weight.
      settle();
      write_csr(CSR_UNUSED, {$urandom, $urandom});
      write_csr(CSR_RMS_THRESHOLD, 64'hFFFF_FFFF_FFFF_0000);
      write_csr(CSR_EMA_WEIGHT, 64'h0);
      write_csr(CSR_CHANNEL_MASK, '1);
      send_word(6'd9, 16'shFFFF, 1'b0);
      send_word(6'd20, 16'sd40, 1'b1);

      // Largest threshold and weight.
      settle();
      write_csr(CSR_RMS_THRESHOLD, 64'h0000_0000_0000_FFFF);
      write_csr(CSR_EMA_WEIGHT, 64'h0000_0000_0000_FFFF);
      send_word(6'd0, 16'sh7FFF, 1'b0);
      send_word(6'd1, 16'sh8000, 1'b1);

      for (int p = 0; p < PHASES; p++) begin
         settle();
         load_random_config();
         run_phase(PHASE_WORDS, send_gaps[p % 4], recv_stalls[p % 4]);
      end

      settle();
      foreach (board.awaited_picks[i]) begin
         $display("%0t: selection never arrived: channel %0d, mean square %0d", $time,
                  board.awaited_picks[i].selected_channel,
                  board.awaited_picks[i].selected_mean_square);
         board.mismatches++;
      end
      if (board.mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
